// ----- rtl/ramt_pkg.sv -----
`timescale 1ns / 1ps

package ramt_pkg;

    localparam int          LEAF_COUNT_DEF = 1024;
    localparam int          POS_IN_W       = 11;
    localparam int          DATA_W         = 32;
    localparam logic [31:0] INT_MIN        = 32'h8000_0000;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd_node;
        logic eval;
        logic rd_c1;
        logic wr_c1;
        logic rd_c2;
        logic wr_c2;
        logic decide;
        logic up;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic empty;
        logic query;
        logic push;
        logic disjoint;
        logic covered;
        logic at_root;
        logic phase;
        logic out_busy;
    } status_t;

    function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

// ----- rtl/ramt_if.sv -----
`timescale 1ns / 1ps

interface ramt_op_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] range_start;
    logic [10:0] range_end;
    logic signed [31:0] addend;

    modport source (output valid, kind, range_start, range_end, addend, input ready);
    modport sink (input valid, kind, range_start, range_end, addend, output ready);
endinterface

interface ramt_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] max_value;
    logic        range_empty;

    modport source (output valid, max_value, range_empty, input ready);
    modport sink (input valid, max_value, range_empty, output ready);
endinterface

// ----- rtl/ramt_ram.sv -----
`timescale 1ns / 1ps

module ramt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/ramt_ctrl.sv -----
`timescale 1ns / 1ps

module ramt_ctrl
    import ramt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_RD, ST_EVAL, ST_C1R, ST_C1W,
        ST_C2R, ST_C2W, ST_DECIDE, ST_UP, ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!st.empty)
                begin
                    state_next = ST_RD;
                end
                else if (st.query)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_node = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = st.push ? ST_C1R : ST_DECIDE;
            end
            ST_C1R:
            begin
                cmd.rd_c1  = 1'b1;
                state_next = ST_C1W;
            end
            ST_C1W:
            begin
                cmd.wr_c1  = 1'b1;
                state_next = ST_C2R;
            end
            ST_C2R:
            begin
                cmd.rd_c2  = 1'b1;
                state_next = ST_C2W;
            end
            ST_C2W:
            begin
                cmd.wr_c2  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = (st.disjoint || st.covered) ? ST_UP : ST_RD;
            end
            ST_UP:
            begin
                cmd.up = 1'b1;
                if (st.at_root)
                begin
                    state_next = ST_FIN;
                end
                else if (!st.phase)
                begin
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!st.query)
                begin
                    state_next = ST_IDLE;
                end
                else if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/ramt_dp.sv -----
`timescale 1ns / 1ps

module ramt_dp
    import ramt_pkg::*;
#(
    parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ramt_op_if.sink     in_ch,
    ramt_res_if.source  out_ch,
    input  cmd_t        cmd,
    output status_t     st
);

    localparam int SPAN_LOG = $clog2(LEAF_COUNT);
    localparam int POS_W    = SPAN_LOG + 1;
    localparam int DEPTH    = 2 * (1 << SPAN_LOG) - 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LVL_N    = SPAN_LOG + 1;
    localparam int LVL_W    = $clog2(LVL_N);
    localparam int CW       = (POS_W > POS_IN_W) ? POS_W : POS_IN_W;
    localparam logic [POS_W-1:0] SPAN_P = POS_W'(1 << SPAN_LOG);
    localparam logic [CW-1:0]    LEAF_C = CW'(LEAF_COUNT);

    logic [POS_W-1:0]  l_reg, r_reg, lb_reg;
    logic [31:0]       x_reg, node_val_reg, peff_reg, ret_reg;
    logic              query_reg, empty_reg;
    logic [ADDR_W-1:0] id_reg, clr_cnt_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [31:0]       frame_left_reg [LVL_N];
    logic              frame_phase_reg [LVL_N];
    logic              out_valid_reg, out_empty_reg;
    logic [31:0]       out_max_reg;

    logic              max_we, pend_we;
    logic [ADDR_W-1:0] max_addr, pend_addr;
    logic [31:0]       max_wdata, pend_wdata, max_rd, pend_rd;

    logic [CW-1:0]     l_in, r_in;
    logic [POS_W-1:0]  l_clamp, r_clamp, w, rb;
    logic [ADDR_W-1:0] c1, parent;
    logic [LVL_W-1:0]  plvl;
    logic              covered, disjoint;
    logic [31:0]       peff, new_max, up_max;

    assign l_in    = CW'(in_ch.range_start);
    assign r_in    = CW'(in_ch.range_end);
    assign l_clamp = (l_in > LEAF_C) ? POS_W'(LEAF_C) : POS_W'(l_in);
    assign r_clamp = (r_in > LEAF_C) ? POS_W'(LEAF_C) : POS_W'(r_in);

    assign w        = SPAN_P >> lvl_reg;
    assign rb       = lb_reg + w;
    assign covered  = (l_reg <= lb_reg) && (rb <= r_reg);
    assign disjoint = (lb_reg >= r_reg) || (rb <= l_reg);
    assign c1       = {id_reg[ADDR_W-2:0], 1'b1};
    assign parent   = (id_reg - ADDR_W'(1)) >> 1;
    assign plvl     = lvl_reg - LVL_W'(1);
    assign peff     = pend_rd + ((!query_reg && covered) ? x_reg : 32'd0);
    assign new_max  = max_rd + peff;
    assign up_max   = smax(frame_left_reg[plvl], ret_reg);

    assign st.clr_done = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign st.empty    = empty_reg;
    assign st.query    = query_reg;
    assign st.push     = (lvl_reg != LVL_W'(SPAN_LOG)) && (peff != 32'd0);
    assign st.disjoint = disjoint;
    assign st.covered  = covered;
    assign st.at_root  = (lvl_reg == '0);
    assign st.phase    = frame_phase_reg[plvl];
    assign st.out_busy = out_valid_reg && !out_ch.ready;

    always_comb
    begin
        max_we     = 1'b0;
        max_addr   = id_reg;
        max_wdata  = new_max;
        pend_we    = 1'b0;
        pend_addr  = id_reg;
        pend_wdata = 32'd0;
        if (cmd.clr_step)
        begin
            max_we    = 1'b1;
            max_addr  = clr_cnt_reg;
            max_wdata = 32'd0;
            pend_we   = 1'b1;
            pend_addr = clr_cnt_reg;
        end
        else if (cmd.eval)
        begin
            max_we  = 1'b1;
            pend_we = 1'b1;
        end
        else if (cmd.rd_c1)
        begin
            pend_addr = c1;
        end
        else if (cmd.wr_c1)
        begin
            pend_we    = 1'b1;
            pend_addr  = c1;
            pend_wdata = pend_rd + peff_reg;
        end
        else if (cmd.rd_c2)
        begin
            pend_addr = c1 + ADDR_W'(1);
        end
        else if (cmd.wr_c2)
        begin
            pend_we    = 1'b1;
            pend_addr  = c1 + ADDR_W'(1);
            pend_wdata = pend_rd + peff_reg;
        end
        else if (cmd.up)
        begin
            max_addr  = parent;
            max_wdata = up_max;
            max_we    = !query_reg && !st.at_root && frame_phase_reg[plvl];
        end
    end

    ramt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .addr  (max_addr),
        .wdata (max_wdata),
        .rdata (max_rd)
    );

    ramt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .addr  (pend_addr),
        .wdata (pend_wdata),
        .rdata (pend_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg     <= l_clamp;
            r_reg     <= r_clamp;
            x_reg     <= in_ch.addend;
            query_reg <= (in_ch.kind == KIND_QUERY);
            empty_reg <= (l_clamp >= r_clamp);
            id_reg    <= '0;
            lvl_reg   <= '0;
            lb_reg    <= '0;
            ret_reg   <= INT_MIN;
        end
        if (cmd.eval)
        begin
            node_val_reg <= new_max;
            peff_reg     <= peff;
        end
        if (cmd.decide)
        begin
            if (disjoint || covered)
            begin
                ret_reg <= (query_reg && disjoint) ? INT_MIN : node_val_reg;
            end
            else
            begin
                frame_phase_reg[lvl_reg] <= 1'b0;
                id_reg                   <= c1;
                lvl_reg                  <= lvl_reg + LVL_W'(1);
            end
        end
        if (cmd.up && !st.at_root)
        begin
            if (!frame_phase_reg[plvl])
            begin
                frame_left_reg[plvl]  <= ret_reg;
                frame_phase_reg[plvl] <= 1'b1;
                id_reg                <= id_reg + ADDR_W'(1);
                lb_reg                <= lb_reg + w;
            end
            else
            begin
                ret_reg <= up_max;
                id_reg  <= parent;
                lvl_reg <= plvl;
                lb_reg  <= lb_reg - w;
            end
        end
        if (cmd.out_load)
        begin
            out_max_reg   <= ret_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign in_ch.ready        = 1'b0 | 1'b0;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.max_value   = out_max_reg;
    assign out_ch.range_empty = out_empty_reg;

endmodule

// ----- rtl/range_add_range_max_tree.sv -----
`timescale 1ns / 1ps
// range-add / range-max tree over LEAF_COUNT signed 32-bit positions
// in_ch: one beat per operation, kind selects add (0) or max query (1)
//   over the half-open range [range_start, range_end), clamped to LEAF_COUNT
// out_ch: one beat per query with max_value and range_empty; adds give none
// one operation at a time: a controller walks the tree node by node over
//   two single-port node memories (maximum and pending add)
// each visited node is read, evaluated and decided; when its pending add is
//   pushed to its children, each child is also read and written, and the node
//   takes a return step; an operation visits at most about 4 nodes per tree level
// empty ranges skip the walk: an add goes back to idle, a query to its result
// after reset both memories are cleared, one node per cycle, all
//   2 * 2^ceil(log2(LEAF_COUNT)) - 1 nodes (2047 at 1024 leaves);
//   in_ch.ready stays low during that pass
// out_ch holds its beat while the receiver stalls; the block takes the next
//   operation meanwhile and waits only when a new query result is ready
module range_add_range_max_tree
    import ramt_pkg::*;
#(
    parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ramt_op_if.sink    in_ch,
    ramt_res_if.source out_ch
);

    cmd_t    cmd;
    status_t st;
    logic    ready;

    ramt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    ramt_op_if dp_in ();

    assign dp_in.valid       = in_ch.valid;
    assign dp_in.kind        = in_ch.kind;
    assign dp_in.range_start = in_ch.range_start;
    assign dp_in.range_end   = in_ch.range_end;
    assign dp_in.addend      = in_ch.addend;
    assign in_ch.ready       = ready;

    ramt_dp #(.LEAF_COUNT(LEAF_COUNT)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (dp_in),
        .out_ch (out_ch),
        .cmd    (cmd),
        .st     (st)
    );

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.range_empty |-> out_ch.max_value == INT_MIN)
        else $error("empty range result without most negative value");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("second operation taken while one is in progress");

    a_load_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_ch.valid && in_ch.ready && !cmd.clr_step)
        else $error("operation latched without a handshake");

endmodule

// ----- verif/range_add_range_max_tree_tb.sv -----
`timescale 1ns / 1ps

module testbench;
    import ramt_pkg::*;

    localparam int LEAVES      = 1024;
    localparam int SPAN        = 1 << $clog2(LEAVES);
    localparam int NODES       = 2 * SPAN - 1;
    localparam int WAIT_LIMIT  = 20000;
    localparam int RANDOM_OPS  = 1500;

    typedef struct {
        logic        kind;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [31:0] addend;
        logic        known;
        logic [31:0] want_max;
        logic        want_empty;
    } op_row_t;

    typedef struct {
        logic [31:0] max_value;
        logic        range_empty;
    } max_result_t;

    logic clk;
    logic rst_n;

    ramt_op_if  op_ch ();
    ramt_res_if res_ch ();

    range_add_range_max_tree #(.LEAF_COUNT(LEAVES)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (op_ch.sink),
        .out_ch(res_ch.source)
    );

    logic [31:0]  tree_max [NODES];
    logic [31:0]  tree_pend [NODES];
    max_result_t  pending_maxima [$];
    int           fail_count;
    int           idle_cycles;
    bit           stimulus_done;
    bit           hold_sink;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // lazy tree model, same node layout and 32-bit wrapping as the block
    function automatic void settle(int id, int lb, int rb);
        logic [31:0] p;
        p = tree_pend[id];
        if (p != 32'd0)
        begin
            tree_max[id] = tree_max[id] + p;
            if (lb + 1 < rb)
            begin
                tree_pend[2 * id + 1] = tree_pend[2 * id + 1] + p;
                tree_pend[2 * id + 2] = tree_pend[2 * id + 2] + p;
            end
            tree_pend[id] = 32'd0;
        end
    endfunction

    function automatic void tree_add(int l, int r, logic [31:0] x, int id, int lb, int rb);
        int mid;
        settle(id, lb, rb);
        if (lb >= r || rb <= l)
            return;
        if (l <= lb && rb <= r)
        begin
            tree_pend[id] = tree_pend[id] + x;
            settle(id, lb, rb);
            return;
        end
        mid = lb + (rb - lb) / 2;
        tree_add(l, r, x, 2 * id + 1, lb, mid);
        tree_add(l, r, x, 2 * id + 2, mid, rb);
        tree_max[id] = smax(tree_max[2 * id + 1], tree_max[2 * id + 2]);
    endfunction

    function automatic logic [31:0] tree_query(int l, int r, int id, int lb, int rb);
        int mid;
        settle(id, lb, rb);
        if (lb >= r || rb <= l)
            return INT_MIN;
        if (l <= lb && rb <= r)
            return tree_max[id];
        mid = lb + (rb - lb) / 2;
        return smax(tree_query(l, r, 2 * id + 1, lb, mid),
                    tree_query(l, r, 2 * id + 2, mid, rb));
    endfunction

    function automatic max_result_t apply_op(logic kind, logic [10:0] lo_in,
                                             logic [10:0] hi_in, logic [31:0] addend);
        max_result_t r;
        int lo;
        int hi;
        lo = (int'(lo_in) > LEAVES) ? LEAVES : int'(lo_in);
        hi = (int'(hi_in) > LEAVES) ? LEAVES : int'(hi_in);
        r.max_value   = INT_MIN;
        r.range_empty = (lo >= hi);
        if (!r.range_empty)
        begin
            if (kind == KIND_ADD)
                tree_add(lo, hi, addend, 0, 0, SPAN);
            else
                r.max_value = tree_query(lo, hi, 0, 0, SPAN);
        end
        return r;
    endfunction

    task automatic send_op(op_row_t row);
        max_result_t r;
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_ch.valid       <= 1'b1;
        op_ch.kind        <= row.kind;
        op_ch.range_start <= row.lo;
        op_ch.range_end   <= row.hi;
        op_ch.addend      <= row.addend;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        r = apply_op(row.kind, row.lo, row.hi, row.addend);
        if (row.kind == KIND_QUERY)
        begin
            if (row.known && (r.max_value !== row.want_max
                              || r.range_empty !== row.want_empty))
            begin
                $display("%0t table row disagrees: expected %h/%b predicted %h/%b",
                         $time, row.want_max, row.want_empty, r.max_value, r.range_empty);
                fail_count++;
            end
            if (row.known)
            begin
                r.max_value   = row.want_max;
                r.range_empty = row.want_empty;
            end
            pending_maxima.insert(pending_maxima.size(), r);
        end
    endtask

    function automatic op_row_t mk(logic kind, int lo, int hi, logic [31:0] x,
                                   int known = 0, logic [31:0] wm = 0, int we = 0);
        op_row_t row;
        row.kind = kind;
        row.lo = lo[10:0];
        row.hi = hi[10:0];
        row.addend = x;
        row.known = (known != 0);
        row.want_max = wm;
        row.want_empty = (we != 0);
        return row;
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1025, 2047);
            1:       return $urandom_range(0, 3);
            2:       return $urandom_range(1020, 1024);
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    op_row_t directed_ops [$];

    initial
    begin
        op_row_t row;
        int a;
        int b;
        rst_n = 1'b0;
        op_ch.valid = 1'b0;
        op_ch.kind = KIND_ADD;
        op_ch.range_start = '0;
        op_ch.range_end = '0;
        op_ch.addend = '0;
        fail_count = 0;
        stimulus_done = 0;
        for (int i = 0; i < NODES; i++)
        begin
            tree_max[i]  = '0;
            tree_pend[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_ops = '{
            mk(KIND_QUERY, 0, 1024, 0, 1, 32'h0, 0),
            mk(KIND_QUERY, 5, 5, 0, 1, INT_MIN, 1),
            mk(KIND_QUERY, 9, 3, 0, 1, INT_MIN, 1),
            mk(KIND_QUERY, 1024, 2047, 0, 1, INT_MIN, 1),
            mk(KIND_QUERY, 2047, 2047, 0, 1, INT_MIN, 1),
            mk(KIND_ADD, 0, 2047, 32'h7fff_ffff),
            mk(KIND_QUERY, 0, 1024, 0, 1, 32'h7fff_ffff, 0),
            mk(KIND_ADD, 1023, 1024, 32'h0000_0001),
            mk(KIND_QUERY, 1023, 2000, 0, 1, INT_MIN, 0),
            mk(KIND_QUERY, 0, 1023, 0, 1, 32'h7fff_ffff, 0),
            mk(KIND_ADD, 10, 5, 32'h1234_5678),
            mk(KIND_ADD, 700, 700, 32'hffff_ffff),
            mk(KIND_ADD, 0, 1, 32'h8000_0000),
            mk(KIND_QUERY, 0, 1, 0),
            mk(KIND_QUERY, 0, 2, 0),
            mk(KIND_ADD, 3, 517, 32'hdead_beef),
            mk(KIND_ADD, 1, 1022, 32'h5555_5555),
            mk(KIND_QUERY, 2, 600, 0),
            mk(KIND_QUERY, 511, 513, 0),
            mk(KIND_QUERY, 1, 1024, 0),
            mk(KIND_ADD, 0, 1024, 32'haaaa_aaaa),
            mk(KIND_QUERY, 0, 1024, 0),
            mk(KIND_QUERY, 1000, 1024, 0)
        };
        foreach (directed_ops[i])
            send_op(directed_ops[i]);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == 400)
            begin
                op_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_maxima.size() != 0)
                    @(posedge clk);
            end
            a = rand_pos();
            b = rand_pos();
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                int t;
                t = a;
                a = b;
                b = t;
            end
            row = mk(1'($urandom_range(0, 1)), a, b, $urandom());
            if ($urandom_range(0, 5) == 0)
                row.addend = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            send_op(row);
        end
        op_ch.valid <= 1'b0;
        stimulus_done = 1;
    end

    // long hold-off once the run is underway so the block backs up
    initial
    begin
        hold_sink = 0;
        wait (rst_n);
        repeat (6000) @(posedge clk);
        hold_sink = 1;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
    end

    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0 || hold_sink)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_sink)
                    @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        max_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_maxima.size() == 0)
            begin
                $display("%0t unexpected result beat: actual %h/%b", $time,
                         res_ch.max_value, res_ch.range_empty);
                fail_count++;
            end
            else
            begin
                want = pending_maxima.pop_front();
                if (res_ch.max_value !== want.max_value)
                begin
                    $display("%0t max_value mismatch: expected %h actual %h", $time,
                             want.max_value, res_ch.max_value);
                    fail_count++;
                end
                if (res_ch.range_empty !== want.range_empty)
                begin
                    $display("%0t range_empty mismatch: expected %b actual %b", $time,
                             want.range_empty, res_ch.range_empty);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        fork
            begin
                wait (stimulus_done);
                while (pending_maxima.size() != 0)
                    @(posedge clk);
                repeat (400) @(posedge clk);
                if (fail_count == 0 && pending_maxima.size() == 0)
                    $display("status: pass");
                else
                    $display("status: fail");
                $finish;
            end
            begin
                wait (idle_cycles >= WAIT_LIMIT);
                $display("timeout with %0d results outstanding", pending_maxima.size());
                $display("status: fail");
                $finish;
            end
        join
    end

endmodule
